@@ hw/rtl/ppb_pkg.sv @@
// Package for the prime power base block: microcode types and program ROM.
package ppb_pkg;

  localparam int PPB_VALUE_WIDTH = 40;

  typedef logic [3:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_X_FROM_Q,
    OP_INC_D,
    OP_RES_N,
    OP_RES_P
  } op_t;

  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_NO_INPUT,
    CND_DIV_BUSY,
    CND_D_GT_Q,
    CND_REM_NZ,
    CND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    logic  emit;
    cond_t cond;
    pc_t   target;
  } uword_t;

  localparam pc_t P_IDLE    = 4'd0;
  localparam pc_t P_TRY     = 4'd1;
  localparam pc_t P_TRY_W   = 4'd2;
  localparam pc_t P_TRY_CHK = 4'd3;
  localparam pc_t P_TRY_HIT = 4'd4;
  localparam pc_t P_FOUND   = 4'd5;
  localparam pc_t P_DIV     = 4'd6;
  localparam pc_t P_DIV_W   = 4'd7;
  localparam pc_t P_DIV_CHK = 4'd8;
  localparam pc_t P_DIV_Q   = 4'd9;
  localparam pc_t P_RES_P   = 4'd10;
  localparam pc_t P_RES_N   = 4'd11;
  localparam pc_t P_EMIT    = 4'd12;
  localparam pc_t P_DONE    = 4'd13;
  localparam pc_t P_NEXT_D  = 4'd14;

  // jump to target when the condition holds, else fall through to the next step
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    w = '{op: OP_NOP, emit: 1'b0, cond: CND_ALWAYS, target: P_IDLE};
    case (pc)
      P_IDLE:    w = '{op: OP_LOAD,      emit: 1'b0, cond: CND_NO_INPUT, target: P_IDLE};
      P_TRY:     w = '{op: OP_DIV_START, emit: 1'b0, cond: CND_ALWAYS,   target: P_TRY_W};
      P_TRY_W:   w = '{op: OP_DIV_STEP,  emit: 1'b0, cond: CND_DIV_BUSY, target: P_TRY_W};
      P_TRY_CHK: w = '{op: OP_NOP,       emit: 1'b0, cond: CND_D_GT_Q,   target: P_RES_N};
      P_TRY_HIT: w = '{op: OP_NOP,       emit: 1'b0, cond: CND_REM_NZ,   target: P_NEXT_D};
      P_FOUND:   w = '{op: OP_X_FROM_Q,  emit: 1'b0, cond: CND_ALWAYS,   target: P_DIV};
      P_DIV:     w = '{op: OP_DIV_START, emit: 1'b0, cond: CND_ALWAYS,   target: P_DIV_W};
      P_DIV_W:   w = '{op: OP_DIV_STEP,  emit: 1'b0, cond: CND_DIV_BUSY, target: P_DIV_W};
      P_DIV_CHK: w = '{op: OP_NOP,       emit: 1'b0, cond: CND_REM_NZ,   target: P_RES_P};
      P_DIV_Q:   w = '{op: OP_X_FROM_Q,  emit: 1'b0, cond: CND_ALWAYS,   target: P_DIV};
      P_RES_P:   w = '{op: OP_RES_P,     emit: 1'b0, cond: CND_ALWAYS,   target: P_EMIT};
      P_RES_N:   w = '{op: OP_RES_N,     emit: 1'b0, cond: CND_ALWAYS,   target: P_EMIT};
      P_EMIT:    w = '{op: OP_NOP,       emit: 1'b1, cond: CND_OUT_BUSY, target: P_EMIT};
      P_DONE:    w = '{op: OP_NOP,       emit: 1'b0, cond: CND_ALWAYS,   target: P_IDLE};
      P_NEXT_D:  w = '{op: OP_INC_D,     emit: 1'b0, cond: CND_ALWAYS,   target: P_TRY};
      default:   w = '{op: OP_NOP,       emit: 1'b0, cond: CND_ALWAYS,   target: P_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/prime_power_base.sv @@
// Prime power base by trial division: microcoded sequencer with a bit-serial divider.
// Each trial divisor runs the shared restoring divider, one quotient bit per cycle; up to
// about 2^(VALUE_WIDTH/2) trials for a prime, then further divisions by the factor found.
// After the last check the result is registered at the result step and loaded into the
// output register at the emit step, which waits while the output is stalled. One request
// at a time, in_stall high outside idle. Reset idles the sequencer, empties the output.
module prime_power_base #(
  parameter int VALUE_WIDTH = ppb_pkg::PPB_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_value_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] out_prime_base
);
  import ppb_pkg::*;

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  pc_t                   pc_r, pc_nxt;
  uword_t                uw;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] x_r, x_nxt;
  logic [VALUE_WIDTH-1:0] d_r, d_nxt;
  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] res_r, res_nxt;
  logic [VALUE_WIDTH-1:0] outd_r, outd_nxt;
  logic                   outv_r, outv_nxt;
  logic [VALUE_WIDTH:0]   trial, diff;
  logic                   out_busy, cond_hit;

  assign uw       = ucode_rom(pc_r);
  assign out_busy = outv_r & out_stall;
  assign trial    = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign diff     = trial - {1'b0, d_r};

  always_comb begin
    case (uw.cond)
      CND_ALWAYS:   cond_hit = 1'b1;
      CND_NO_INPUT: cond_hit = !in_valid;
      CND_DIV_BUSY: cond_hit = (cnt_r != CW'(1));
      CND_D_GT_Q:   cond_hit = (d_r > quo_r);
      CND_REM_NZ:   cond_hit = (rem_r != '0);
      CND_OUT_BUSY: cond_hit = out_busy;
      default:      cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    pc_nxt   = cond_hit ? uw.target : pc_t'(pc_r + 4'd1);
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    d_nxt    = d_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    outd_nxt = outd_r;
    outv_nxt = outv_r & out_stall;
    case (uw.op)
      OP_LOAD: begin
        x_nxt = in_value_in;
        d_nxt = VALUE_WIDTH'(2);
      end
      OP_DIV_START: begin
        quo_nxt = x_r;
        rem_nxt = '0;
        cnt_nxt = CW'(VALUE_WIDTH);
      end
      OP_DIV_STEP: begin
        cnt_nxt = cnt_r - CW'(1);
        if (!diff[VALUE_WIDTH]) begin
          rem_nxt = diff[VALUE_WIDTH-1:0];
          quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b1};
        end else begin
          rem_nxt = trial[VALUE_WIDTH-1:0];
          quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b0};
        end
      end
      OP_X_FROM_Q: x_nxt = quo_r;
      OP_INC_D:    d_nxt = d_r + VALUE_WIDTH'(1);
      OP_RES_N:    res_nxt = x_r;
      OP_RES_P:    res_nxt = (x_r == VALUE_WIDTH'(1)) ? d_r : VALUE_WIDTH'(1);
      default: ;
    endcase
    if (uw.emit && !out_busy) begin
      outd_nxt = res_r;
      outv_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= P_IDLE;
      outv_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      pc_r   <= pc_nxt;
      outv_r <= outv_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    d_r    <= d_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
    outd_r <= outd_nxt;
  end

  assign in_stall       = (pc_r != P_IDLE);
  assign out_valid      = outv_r;
  assign out_prime_base = outd_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sequencer did not leave idle after a request");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(VALUE_WIDTH))
    else $error("divider step count out of range");

  a_trial_ge2: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r != P_IDLE) |-> (d_r >= VALUE_WIDTH'(2)))
    else $error("trial divisor below two");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(pc_r == P_EMIT))
    else $error("result loaded outside the emit step");

endmodule

@@ test/prime_power_base_test.sv @@
// Testbench for prime_power_base: directed and random requests checked against a local predictor.
module prime_power_base_test;

  localparam int W = ppb_pkg::PPB_VALUE_WIDTH;
  localparam longint unsigned VALUE_SPAN = 64'd1 << W;

  typedef logic [W-1:0] value_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  value_t in_value_in = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  value_t out_prime_base;

  value_t          pending_bases[$];
  value_t          pending_inputs[$];
  int              mismatches = 0;
  int              results_checked = 0;
  int              requests_sent = 0;
  longint unsigned cycle_count = 0;
  longint unsigned work_cycles = 0;
  int              hold_off_request = 0;
  bit              stall_enable = 1'b0;

  prime_power_base #(.VALUE_WIDTH(W)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value_in    (in_value_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_prime_base (out_prime_base)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 64'd200000 + 4 * work_cycles) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // smallest divisor d with d*d <= n, then strip every factor d
  function automatic value_t predict_base(input value_t n, output int unsigned steps);
    longint unsigned nn;
    longint unsigned d;
    longint unsigned found;
    longint unsigned rest;
    nn = n;
    d = 2;
    found = 0;
    steps = 1;
    while (found == 0 && d <= nn / d) begin
      steps++;
      if (nn % d == 0) found = d;
      else d++;
    end
    if (found == 0) return n;
    rest = nn;
    while (rest % found == 0) begin
      rest = rest / found;
      steps++;
    end
    return (rest == 1) ? value_t'(found) : value_t'(1);
  endfunction

  function automatic bit is_prime(input longint unsigned p);
    longint unsigned d;
    if (p < 2) return 1'b0;
    for (d = 2; d * d <= p; d++) begin
      if (p % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic longint unsigned draw_prime(input int unsigned lo, input int unsigned hi);
    longint unsigned p;
    p = $urandom_range(hi, lo);
    while (!is_prime(p)) p = $urandom_range(hi, lo);
    return p;
  endfunction

  // mostly cheap values: the cost of a request grows with its smallest divisor
  function automatic value_t draw_value();
    int unsigned     pick;
    int unsigned     steps;
    longint unsigned p;
    longint unsigned q;
    longint unsigned pw;
    longint unsigned raw;
    int unsigned     kmax;
    int unsigned     k;
    value_t          v;
    pick = $urandom_range(99);
    if (pick < 40) begin
      steps = 1000;
      while (steps > 66) begin
        raw = {$urandom, $urandom};
        if ($urandom_range(9) < 4) raw = raw & ((64'd1 << $urandom_range(W, 1)) - 1);
        v = value_t'(raw);
        void'(predict_base(v, steps));
      end
      return v;
    end else if (pick < 62) begin
      p = draw_prime(2, 200);
      pw = p;
      kmax = 1;
      while (pw * p < VALUE_SPAN) begin
        pw = pw * p;
        kmax++;
      end
      k = $urandom_range(kmax, 2);
      pw = 1;
      repeat (k) pw = pw * p;
      return value_t'(pw);
    end else if (pick < 80) begin
      p = draw_prime(2, 200);
      q = $urandom_range(1000, 2);
      while (q % p == 0) q = $urandom_range(1000, 2);
      pw = p * q;
      kmax = $urandom_range(30, 0);
      while (kmax > 0 && pw * p < VALUE_SPAN) begin
        pw = pw * p;
        kmax--;
      end
      return value_t'(pw);
    end else if (pick < 95) begin
      return value_t'($urandom_range(65535, 0));
    end else begin
      return value_t'(draw_prime(65536, 262143));
    end
  endfunction

  task automatic send_request(input value_t n);
    int unsigned steps;
    value_t      base;
    @(negedge clk);
    in_valid <= 1'b1;
    in_value_in <= n;
    do @(posedge clk); while (in_stall);
    base = predict_base(n, steps);
    pending_bases = {pending_bases, base};
    pending_inputs = {pending_inputs, n};
    work_cycles += longint'(steps + 2) * (W + 4) + 400;
    requests_sent++;
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    idle_sender(1);
    while (pending_bases.size() != 0) @(posedge clk);
  endtask

  // receiver: long hold-offs on request, else stalls from a random 16-bit pattern when enabled
  initial begin : receiver
    int          hold_left;
    int          phase;
    logic [15:0] pattern;
    hold_left = 0;
    phase = 0;
    pattern = '0;
    forever begin
      @(negedge clk);
      if (hold_off_request != 0) begin
        hold_left = hold_off_request;
        hold_off_request = 0;
      end
      if (phase == 0) pattern = stall_enable ? 16'($urandom) & 16'($urandom) : 16'h0;
      phase = (phase + 1) % 16;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= pattern[phase];
      end
    end
  end

  always @(posedge clk) begin : result_check
    value_t want;
    value_t n;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bases.size() == 0) begin
        $error("out_prime_base: expected nothing, got %0d", out_prime_base);
        mismatches++;
      end else begin
        want = pending_bases.pop_front();
        n = pending_inputs.pop_front();
        if (out_prime_base !== want) begin
          $error("out_prime_base (n=%0d): expected %0d, got %0d", n, want, out_prime_base);
          mismatches++;
        end
        results_checked++;
      end
    end
  end

  task automatic reset_block();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  endtask

  // zero, one, small primes, squares on the bound, prime powers, composites, field extremes
  task automatic test_directed();
    longint unsigned values[$];
    values = '{0, 1, 2, 3, 4, 6, 8, 9, 35, 45, 97, 961, 1024, 65521, 1048573,
               64'd549755813888, 64'd847288609443, 64'd678223072849,
               VALUE_SPAN - 2, VALUE_SPAN - 1};
    stall_enable = 1'b0;
    foreach (values[i]) send_request(value_t'(values[i]));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count, input bit bursty);
    int burst;
    stall_enable = bursty;
    while (count > 0) begin
      burst = bursty ? $urandom_range(8, 1) : count;
      while (burst > 0 && count > 0) begin
        send_request(draw_value());
        burst--;
        count--;
      end
      if (bursty) idle_sender($urandom_range(12, 0));
    end
    wait_drained();
  endtask

  task automatic test_back_pressure();
    stall_enable = 1'b0;
    hold_off_request = 300;
    repeat (6) send_request(value_t'($urandom_range(4095, 0)));
    wait_drained();
  endtask

  initial begin
    reset_block();
    test_directed();
    test_random_traffic(45, 1'b1);
    test_back_pressure();
    test_random_traffic(40, 1'b0);
    wait_drained();
    repeat (W + 8) @(posedge clk);
    mismatches += pending_bases.size();
    $display("Covered %0d requests, %0d results checked: zero, one, primes, prime powers,",
             requests_sent, results_checked);
    $display("composites, full-width values, bursty input, random stalls and a long hold-off.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ppb_pkg.sv
hw/rtl/prime_power_base.sv
test/prime_power_base_test.sv
